// File: hdl/lidar_scan_sample_conditioner_macros.svh
// Assertion macros shared by the sample conditioner RTL.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef LIDAR_SCAN_SAMPLE_CONDITIONER_MACROS_SVH
`define LIDAR_SCAN_SAMPLE_CONDITIONER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lssc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LSSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lssc assertion failed");

`endif

// File: hdl/lssc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lssc_pkg;

   localparam int MAX_POINTS_DEFAULT = 4096;

   localparam int RANGE_W     = 16;
   localparam int INTENSITY_W = 16;
   localparam int INT_OUT_W   = 8;
   localparam int WIN_W       = 12;
   localparam int COUNT_W     = 13;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [WIN_W-1:0]   WINDOW_FIRST_RESET     = 12'd0;
   localparam logic [WIN_W-1:0]   WINDOW_LAST_RESET      = 12'd4095;
   localparam logic [RANGE_W-1:0] RANGE_LOW_RESET        = 16'd25;
   localparam logic [RANGE_W-1:0] RANGE_HIGH_RESET       = 16'd5000;
   localparam logic               INTENSITY_ENABLE_RESET = 1'b0;

   localparam logic [RANGE_W-1:0] RANGE_MARKER = 16'h0001;

   localparam logic [INTENSITY_W-1:0] INT_CLIP_ABOVE = 16'd55000;
   localparam logic [INTENSITY_W-1:0] INT_CLIP_VALUE = 16'd600;
   localparam logic [INTENSITY_W-1:0] INT_KNEE       = 16'd5000;
   localparam logic [INT_OUT_W-1:0]   INT_HIGH_BASE  = 8'd200;

   // Reciprocals for the constant divisions. The high segment divides by 1200:
   // ceil(2^27 / 1200) is exact for every dividend below 2^16. The low segment
   // divides by 25: ceil(2^17 / 25) is exact for every dividend up to 5000.
   localparam int               HIGH_SHIFT = 27;
   localparam logic [16:0]      HIGH_RECIP = 17'd111849;
   localparam int               LOW_SHIFT  = 17;
   localparam logic [12:0]      LOW_RECIP  = 13'd5243;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_FIRST     = 3'd0,
      CSR_WINDOW_LAST      = 3'd1,
      CSR_RANGE_LOW        = 3'd2,
      CSR_RANGE_HIGH       = 3'd3,
      CSR_INTENSITY_ENABLE = 3'd4
   } csr_index_type;

   function automatic logic [INT_OUT_W-1:0] map_intensity(input logic [INTENSITY_W-1:0] raw);
      logic [INTENSITY_W-1:0] v;
      logic [INTENSITY_W-1:0] over;
      logic [32:0]            hi_prod;
      logic [25:0]            lo_prod;
      logic [INT_OUT_W-1:0]   q;
      v = (raw > INT_CLIP_ABOVE) ? INT_CLIP_VALUE : raw;
      over = v - INT_KNEE;
      hi_prod = 33'(over) * 33'(HIGH_RECIP);
      lo_prod = 26'(v[12:0]) * 26'(LOW_RECIP);
      if (v > INT_KNEE) begin
         q = INT_HIGH_BASE + INT_OUT_W'(hi_prod >> HIGH_SHIFT);
      end else begin
         q = INT_OUT_W'(lo_prod >> LOW_SHIFT);
      end
      return q;
   endfunction

endpackage

`default_nettype wire

// File: hdl/lidar_scan_sample_conditioner.sv
// Lidar scan sample conditioner.
// The req channel carries one beat per sample: raw range, raw intensity and a
// frame_last flag. The block numbers samples within the frame, publishes those
// whose index lies in the configured window, marks each published range valid
// when it lies strictly between the two limits, and compresses intensity.
// The rsp channel carries one beat per windowed sample, plus one beat for the
// frame's last sample wherever it falls; that beat carries frame_end and the
// frame error flag. Samples outside the window that are not last give no beat.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// A req beat passes through one input register, then the result register.
// Throughput is one sample per cycle while rsp is not stalled, set by the
// combinational window compare, counter update and intensity mapping between
// those two registers. The input register keeps taking a beat while a result
// waits in the output register; when rsp is stalled and the held sample would
// give a result, req stalls until the output register frees up.
// Reset is synchronous and active high. It empties both registers, zeroes the
// sample index and the frame counters and loads the register defaults.
// The csr port is a plain write port and should be used only while idle.
`timescale 1ns / 1ps
`default_nettype none

`include "lidar_scan_sample_conditioner_macros.svh"

module lidar_scan_sample_conditioner #(
   parameter int MAX_POINTS = lssc_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input sample channel.
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [lssc_pkg::RANGE_W-1:0]        req_range_sample,
   input  wire logic [lssc_pkg::INTENSITY_W-1:0]    req_intensity_sample,
   input  wire logic                                req_frame_last,
   // Result channel.
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [lssc_pkg::RANGE_W-1:0]             rsp_range_out,
   output logic                                     rsp_range_valid,
   output logic [lssc_pkg::INT_OUT_W-1:0]           rsp_intensity_out,
   output logic                                     rsp_in_window,
   output logic                                     rsp_frame_end,
   output logic                                     rsp_frame_error,
   // Register write port.
   input  wire logic                                csr_write_enable,
   input  wire logic [lssc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [lssc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   // The window registers are 12 bits; compare at the wider of the two widths
   // so that indices beyond the 12-bit range never fall inside the window.
   localparam int CMP_W = (IDX_W > lssc_pkg::WIN_W) ? IDX_W : lssc_pkg::WIN_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_POINTS - 1);

   // Configuration registers.
   logic [lssc_pkg::WIN_W-1:0]   window_first_ff;
   logic [lssc_pkg::WIN_W-1:0]   window_last_ff;
   logic [lssc_pkg::RANGE_W-1:0] range_low_ff;
   logic [lssc_pkg::RANGE_W-1:0] range_high_ff;
   logic                         intensity_enable_ff;

   // Frame state.
   logic [IDX_W-1:0]             sample_index_ff;
   logic [IDX_W-1:0]             sample_index_in;
   logic [lssc_pkg::COUNT_W-1:0] window_count_ff;
   logic [lssc_pkg::COUNT_W-1:0] window_count_in;
   logic [lssc_pkg::COUNT_W-1:0] marker_fault_count_ff;
   logic [lssc_pkg::COUNT_W-1:0] marker_fault_count_in;
   logic [lssc_pkg::COUNT_W-1:0] limit_fault_count_ff;
   logic [lssc_pkg::COUNT_W-1:0] limit_fault_count_in;

   // Input register.
   logic                             s1_valid_ff;
   logic [lssc_pkg::RANGE_W-1:0]     s1_range_ff;
   logic [lssc_pkg::INTENSITY_W-1:0] s1_intensity_ff;
   logic                             s1_last_ff;

   // Result register.
   logic                             rsp_valid_ff;
   logic [lssc_pkg::RANGE_W-1:0]     rsp_range_ff;
   logic                             rsp_range_valid_ff;
   logic [lssc_pkg::INT_OUT_W-1:0]   rsp_intensity_ff;
   logic                             rsp_in_window_ff;
   logic                             rsp_frame_end_ff;
   logic                             rsp_frame_error_ff;

   logic [CMP_W-1:0]               idx_ext;
   logic                           in_window;
   logic                           range_ok;
   logic                           is_marker;
   logic                           produce;
   logic                           out_free;
   logic                           s1_fire;
   logic                           req_fire;
   logic                           frame_error;
   logic [lssc_pkg::INT_OUT_W-1:0] intensity_mapped;

   // ------------------------------------------------------------------
   // Register writes. Indices past the register list are ignored.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         window_first_ff     <= lssc_pkg::WINDOW_FIRST_RESET;
         window_last_ff      <= lssc_pkg::WINDOW_LAST_RESET;
         range_low_ff        <= lssc_pkg::RANGE_LOW_RESET;
         range_high_ff       <= lssc_pkg::RANGE_HIGH_RESET;
         intensity_enable_ff <= lssc_pkg::INTENSITY_ENABLE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            lssc_pkg::CSR_WINDOW_FIRST: begin
               window_first_ff <= csr_wdata[lssc_pkg::WIN_W-1:0];
            end
            lssc_pkg::CSR_WINDOW_LAST: begin
               window_last_ff <= csr_wdata[lssc_pkg::WIN_W-1:0];
            end
            lssc_pkg::CSR_RANGE_LOW: begin
               range_low_ff <= csr_wdata[lssc_pkg::RANGE_W-1:0];
            end
            lssc_pkg::CSR_RANGE_HIGH: begin
               range_high_ff <= csr_wdata[lssc_pkg::RANGE_W-1:0];
            end
            lssc_pkg::CSR_INTENSITY_ENABLE: begin
               intensity_enable_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Per-sample logic on the held input sample.
   // ------------------------------------------------------------------
   always_comb begin
      idx_ext   = CMP_W'(sample_index_ff);
      in_window = (idx_ext >= CMP_W'(window_first_ff)) && (idx_ext <= CMP_W'(window_last_ff));
      range_ok  = (s1_range_ff > range_low_ff) && (s1_range_ff < range_high_ff);
      is_marker = (s1_range_ff == lssc_pkg::RANGE_MARKER);
      produce   = in_window || s1_last_ff;
      intensity_mapped = intensity_enable_ff ? lssc_pkg::map_intensity(s1_intensity_ff) : '0;
   end

   // The held sample leaves when it gives no result, or when the output
   // register is empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && (!produce || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_fire  = req_valid && !req_stall;

   // Counters include the current sample before the frame error test.
   always_comb begin
      window_count_in       = window_count_ff;
      marker_fault_count_in = marker_fault_count_ff;
      limit_fault_count_in  = limit_fault_count_ff;
      if (in_window) begin
         if (window_count_ff != lssc_pkg::COUNT_MAX) begin
            window_count_in = window_count_ff + 1'b1;
         end
         if (is_marker && (marker_fault_count_ff != lssc_pkg::COUNT_MAX)) begin
            marker_fault_count_in = marker_fault_count_ff + 1'b1;
         end
         if (!range_ok && (limit_fault_count_ff != lssc_pkg::COUNT_MAX)) begin
            limit_fault_count_in = limit_fault_count_ff + 1'b1;
         end
      end
      frame_error = (window_count_in == marker_fault_count_in) ||
                    (window_count_in == limit_fault_count_in);
      sample_index_in = (sample_index_ff == IDX_LAST) ? '0 : sample_index_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff       <= '0;
         window_count_ff       <= '0;
         marker_fault_count_ff <= '0;
         limit_fault_count_ff  <= '0;
      end else if (s1_fire) begin
         if (s1_last_ff) begin
            sample_index_ff       <= '0;
            window_count_ff       <= '0;
            marker_fault_count_ff <= '0;
            limit_fault_count_ff  <= '0;
         end else begin
            sample_index_ff       <= sample_index_in;
            window_count_ff       <= window_count_in;
            marker_fault_count_ff <= marker_fault_count_in;
            limit_fault_count_ff  <= limit_fault_count_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Input register.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_range_ff     <= req_range_sample;
         s1_intensity_ff <= req_intensity_sample;
         s1_last_ff      <= req_frame_last;
      end
   end

   // ------------------------------------------------------------------
   // Result register. It loads only when free, so a stalled beat holds.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_fire && produce;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_fire && produce) begin
         rsp_range_ff       <= s1_range_ff;
         rsp_range_valid_ff <= range_ok;
         rsp_intensity_ff   <= intensity_mapped;
         rsp_in_window_ff   <= in_window;
         rsp_frame_end_ff   <= s1_last_ff;
         rsp_frame_error_ff <= s1_last_ff && frame_error;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_range_out     = rsp_range_ff;
   assign rsp_range_valid   = rsp_range_valid_ff;
   assign rsp_intensity_out = rsp_intensity_ff;
   assign rsp_in_window     = rsp_in_window_ff;
   assign rsp_frame_end     = rsp_frame_end_ff;
   assign rsp_frame_error   = rsp_frame_error_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `LSSC_ASSERT_SAME(a_error_only_at_end, clock, reset, rsp_valid_ff && rsp_frame_error_ff, rsp_frame_end_ff)
   `LSSC_ASSERT_SAME(a_result_in_window, clock, reset, rsp_valid_ff && !rsp_frame_end_ff, rsp_in_window_ff)
   `LSSC_ASSERT_NEXT(a_frame_clears, clock, reset, s1_fire && s1_last_ff, (sample_index_ff == '0) && (window_count_ff == '0))
   `LSSC_ASSERT_SAME(a_fault_bound, clock, reset, 1'b1, (marker_fault_count_ff <= window_count_ff) && (limit_fault_count_ff <= window_count_ff))

endmodule

`default_nettype wire

// File: verif/lssc_stream_checker.sv
`timescale 1ns / 1ps

// Watches the sample, result and register ports of the conditioner. It keeps its
// own copy of the registers and frame counters, works out the result beat that
// each accepted sample should cause, and compares result beats in order.
module lssc_stream_checker #(
   parameter int MAX_POINTS = 4096
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_stall,
   input  wire logic [lssc_pkg::RANGE_W-1:0]          req_range_sample,
   input  wire logic [lssc_pkg::INTENSITY_W-1:0]      req_intensity_sample,
   input  wire logic                                  req_frame_last,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   input  wire logic [lssc_pkg::RANGE_W-1:0]          rsp_range_out,
   input  wire logic                                  rsp_range_valid,
   input  wire logic [lssc_pkg::INT_OUT_W-1:0]        rsp_intensity_out,
   input  wire logic                                  rsp_in_window,
   input  wire logic                                  rsp_frame_end,
   input  wire logic                                  rsp_frame_error,
   input  wire logic                                  csr_write_enable,
   input  wire logic [lssc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [lssc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                         failures,
   output int                                         outstanding,
   output int                                         results_checked
);

   localparam logic [12:0]  SAT_MAX      = 13'h1FFF;
   localparam logic [15:0]  FAULT_MARKER = 16'd1;
   localparam int unsigned  CLIP_ABOVE   = 55000;
   localparam int unsigned  CLIP_VALUE   = 600;
   localparam int unsigned  KNEE         = 5000;
   localparam int unsigned  HIGH_BASE    = 200;
   localparam int unsigned  HIGH_STEP    = 1200;
   localparam int unsigned  LOW_STEP     = 25;
   localparam int           REPORT_LIMIT = 200;

   typedef struct packed {
      logic [15:0] range_raw;
      logic        range_ok;
      logic [7:0]  intensity;
      logic        in_window;
      logic        frame_end;
      logic        frame_error;
   } sample_result_type;

   sample_result_type expected_q[$];
   sample_result_type oldest;

   logic [11:0] win_first;
   logic [11:0] win_last;
   logic [15:0] limit_low;
   logic [15:0] limit_high;
   logic        intensity_on;

   int unsigned sample_idx;
   logic [12:0] windowed_count;
   logic [12:0] marker_count;
   logic [12:0] out_of_limit_count;

   function automatic logic [12:0] bump(input logic [12:0] count);
      return (count == SAT_MAX) ? count : count + 13'd1;
   endfunction

   function automatic logic [7:0] compress_intensity(input logic [15:0] raw);
      int unsigned level;
      level = 32'(raw);
      if (level > CLIP_ABOVE) begin
         level = CLIP_VALUE;
      end
      if (level > KNEE) begin
         return 8'(HIGH_BASE + (level - KNEE) / HIGH_STEP);
      end
      return 8'(level / LOW_STEP);
   endfunction

   task automatic condition_sample(input logic [15:0] range_raw, input logic [15:0] intensity_raw,
                                   input logic last);
      logic              in_win;
      logic              range_ok;
      logic              error_flag;
      sample_result_type result;
      in_win = (sample_idx >= int'(win_first)) && (sample_idx <= int'(win_last));
      range_ok = (range_raw > limit_low) && (range_raw < limit_high);
      error_flag = 1'b0;
      if (in_win) begin
         windowed_count = bump(windowed_count);
         if (range_raw == FAULT_MARKER) begin
            marker_count = bump(marker_count);
         end
         if (!range_ok) begin
            out_of_limit_count = bump(out_of_limit_count);
         end
      end
      // The sample is counted before the frame test, then the frame starts over.
      if (last) begin
         error_flag = (windowed_count == marker_count) || (windowed_count == out_of_limit_count);
         sample_idx = 0;
         windowed_count = '0;
         marker_count = '0;
         out_of_limit_count = '0;
      end else begin
         sample_idx = (sample_idx + 1 >= MAX_POINTS) ? 0 : sample_idx + 1;
      end
      if (in_win || last) begin
         result.range_raw = range_raw;
         result.range_ok = range_ok;
         result.intensity = intensity_on ? compress_intensity(intensity_raw) : 8'd0;
         result.in_window = in_win;
         result.frame_end = last;
         result.frame_error = error_flag;
         expected_q.push_back(result);
      end
   endtask

   task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_q.delete();
         win_first <= 12'd0;
         win_last <= 12'd4095;
         limit_low <= 16'd25;
         limit_high <= 16'd5000;
         intensity_on <= 1'b0;
         sample_idx = 0;
         windowed_count = '0;
         marker_count = '0;
         out_of_limit_count = '0;
         failures = 0;
         outstanding = 0;
         results_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_q.size() == 0) begin
               failures++;
               $display("%0t ns: result beat expected none, actual range %0d frame_end %0d",
                        $time, rsp_range_out, rsp_frame_end);
            end else begin
               oldest = expected_q.pop_front();
               check_field("range_out", oldest.range_raw, rsp_range_out);
               check_field("range_valid", 16'(oldest.range_ok), 16'(rsp_range_valid));
               check_field("intensity_out", 16'(oldest.intensity), 16'(rsp_intensity_out));
               check_field("in_window", 16'(oldest.in_window), 16'(rsp_in_window));
               check_field("frame_end", 16'(oldest.frame_end), 16'(rsp_frame_end));
               check_field("frame_error", 16'(oldest.frame_error), 16'(rsp_frame_error));
            end
         end
         if (req_valid && !req_stall) begin
            condition_sample(req_range_sample, req_intensity_sample, req_frame_last);
         end
         if (csr_write_enable) begin
            case (csr_index)
               lssc_pkg::CSR_WINDOW_FIRST:     win_first <= csr_wdata[11:0];
               lssc_pkg::CSR_WINDOW_LAST:      win_last <= csr_wdata[11:0];
               lssc_pkg::CSR_RANGE_LOW:        limit_low <= csr_wdata;
               lssc_pkg::CSR_RANGE_HIGH:       limit_high <= csr_wdata;
               lssc_pkg::CSR_INTENSITY_ENABLE: intensity_on <= csr_wdata[0];
               default: ;
            endcase
         end
         outstanding = expected_q.size();
      end
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

// Top of the conditioner testbench. It makes the clock, the single reset, the
// sample beats, the result stalls and the register writes. All checking lives
// in lssc_stream_checker, which sits beside the block and hands back a count
// of failures and of results still awaited.
module tb;

   typedef enum int {MIXED_FRAME, MARKER_FRAME, LIMIT_FRAME} frame_style_type;

   // Long enough that both of the block's registers fill and its input stalls.
   localparam int HOLD_CYCLES = 200;
   // The block has an input and a result register; a sample that gives no
   // result may still be inside when the last result leaves; this waits it out.
   localparam int SETTLE_CYCLES = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_range_sample = '0;
   logic [15:0] req_intensity_sample = '0;
   logic        req_frame_last = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_range_out;
   logic        rsp_range_valid;
   logic [7:0]  rsp_intensity_out;
   logic        rsp_in_window;
   logic        rsp_frame_end;
   logic        rsp_frame_error;

   logic                    csr_write_enable = 1'b0;
   lssc_pkg::csr_index_type csr_index = lssc_pkg::CSR_WINDOW_FIRST;
   logic [15:0]             csr_wdata = '0;

   int failures;
   int outstanding;
   int results_checked;

   // Idling control. With quiet set neither side idles; hold requests are
   // counted here and served by the receiver's own process.
   logic quiet = 1'b0;
   int   holds_asked = 0;
   int   holds_granted = 0;
   int   hold_left = 0;

   int samples_sent = 0;
   int frames_sent = 0;
   int settings_applied = 0;

   // The limits now in force, so that ranges can be aimed at their edges.
   logic [15:0] cfg_low = 16'd25;
   logic [15:0] cfg_high = 16'd5000;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lidar_scan_sample_conditioner dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_range_sample     (req_range_sample),
      .req_intensity_sample (req_intensity_sample),
      .req_frame_last       (req_frame_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_range_out        (rsp_range_out),
      .rsp_range_valid      (rsp_range_valid),
      .rsp_intensity_out    (rsp_intensity_out),
      .rsp_in_window        (rsp_in_window),
      .rsp_frame_end        (rsp_frame_end),
      .rsp_frame_error      (rsp_frame_error),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   lssc_stream_checker monitor (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_range_sample     (req_range_sample),
      .req_intensity_sample (req_intensity_sample),
      .req_frame_last       (req_frame_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_range_out        (rsp_range_out),
      .rsp_range_valid      (rsp_range_valid),
      .rsp_intensity_out    (rsp_intensity_out),
      .rsp_in_window        (rsp_in_window),
      .rsp_frame_end        (rsp_frame_end),
      .rsp_frame_error      (rsp_frame_error),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .failures             (failures),
      .outstanding          (outstanding),
      .results_checked      (results_checked)
   );

   // Result side. A requested hold keeps stall high for the span of HOLD_CYCLES,
   // counted here; otherwise the receiver stalls at random, 22 times in 100,
   // unless the quiet stretch is on.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_granted != holds_asked) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         holds_granted <= holds_granted + 1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 22);
      end
   end

   // The run must end even if the block hangs.
   initial begin
      #5_000_000;
      $display("lidar_scan_sample_conditioner: mismatch");
      $finish;
   end

   // Drives one sample beat and returns at the edge where it is taken. Stall
   // is read at the falling edge, where it already holds the value that the
   // next rising edge will see, so the outcome does not hinge on event order.
   task automatic send_sample(input logic [15:0] range_raw, input logic [15:0] intensity_raw,
                              input logic last);
      logic stalled;
      while (!quiet && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_range_sample <= range_raw;
      req_intensity_sample <= intensity_raw;
      req_frame_last <= last;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      samples_sent++;
      if (last) begin
         frames_sent++;
      end
   endtask

   // Drops valid and waits until every awaited result has been taken, then
   // gives samples that cause no result time to leave the block.
   task automatic wait_for_drain;
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input lssc_pkg::csr_index_type which, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes all five registers. Only the low bits of the window and enable
   // words count, so the upper bits may carry anything.
   task automatic apply_settings(input logic [15:0] first_word, last_word, low_word, high_word,
                                 enable_word);
      write_register(lssc_pkg::CSR_WINDOW_FIRST, first_word);
      write_register(lssc_pkg::CSR_WINDOW_LAST, last_word);
      write_register(lssc_pkg::CSR_RANGE_LOW, low_word);
      write_register(lssc_pkg::CSR_RANGE_HIGH, high_word);
      write_register(lssc_pkg::CSR_INTENSITY_ENABLE, enable_word);
      csr_write_enable <= 1'b0;
      cfg_low = low_word;
      cfg_high = high_word;
      settings_applied++;
   endtask

   // Ranges lean toward the fault marker, both limits and the ends of the field.
   function automatic logic [15:0] pick_range();
      case ($urandom_range(9))
         0:       return 16'd1;
         1:       return cfg_low;
         2:       return cfg_low + 16'd1;
         3:       return cfg_high;
         4:       return cfg_high - 16'd1;
         5:       return 16'd0;
         6:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Zero and full scale are never strictly inside the limits, nor are the
   // limits themselves.
   function automatic logic [15:0] pick_out_of_limit();
      case ($urandom_range(3))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return cfg_low;
         default: return cfg_high;
      endcase
   endfunction

   // Intensities cover the steps of the low segment, the knee, the steps of
   // the high segment and the clip point.
   function automatic logic [15:0] pick_intensity();
      case ($urandom_range(11))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'd24;
         3:       return 16'd5000;
         4:       return 16'd5001;
         5:       return 16'd6200;
         6:       return 16'd55000;
         7:       return 16'd55001;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_frame(input int length, input frame_style_type style);
      logic [15:0] range_raw;
      for (int n = 0; n < length; n++) begin
         case (style)
            MARKER_FRAME: range_raw = 16'd1;
            LIMIT_FRAME:  range_raw = pick_out_of_limit();
            default:      range_raw = pick_range();
         endcase
         send_sample(range_raw, pick_intensity(), n == length - 1);
      end
   endtask

   // Whole frames until at least count more samples have gone in. Most frames
   // are short so that windows near index zero see plenty of frame ends; some
   // are all markers or all out of limits so that frame errors come up often.
   task automatic run_random_samples(input int count);
      int              stop_at;
      int              length;
      frame_style_type style;
      stop_at = samples_sent + count;
      while (samples_sent < stop_at) begin
         length = ($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
         case ($urandom_range(7))
            0:       style = MARKER_FRAME;
            1:       style = LIMIT_FRAME;
            default: style = MIXED_FRAME;
         endcase
         send_frame(length, style);
      end
   endtask

   initial begin
      logic [15:0] pick_first;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the full window and the default limits. The first
      // frame walks both limits, the marker and the ends of the range field
      // while the intensity goes through every segment edge.
      apply_settings(16'd0, 16'd4095, 16'd25, 16'd5000, 16'd1);
      send_sample(16'd0, 16'd0, 1'b0);
      send_sample(16'd1, 16'd24, 1'b0);
      send_sample(16'd25, 16'd25, 1'b0);
      send_sample(16'd26, 16'd4999, 1'b0);
      send_sample(16'd4999, 16'd5000, 1'b0);
      send_sample(16'd5000, 16'd5001, 1'b0);
      send_sample(16'hFFFF, 16'd6199, 1'b0);
      send_sample(16'd100, 16'd6200, 1'b0);
      send_sample(16'd200, 16'd55000, 1'b0);
      send_sample(16'd300, 16'd55001, 1'b0);
      send_sample(16'd400, 16'hFFFF, 1'b0);
      send_sample(16'd500, 16'd12345, 1'b1);
      // A frame made only of markers, then one made only of limit faults:
      // both must flag a frame error.
      send_sample(16'd1, 16'd1000, 1'b0);
      send_sample(16'd1, 16'd2000, 1'b1);
      send_sample(16'd0, 16'd3000, 1'b0);
      send_sample(16'd6000, 16'd4000, 1'b1);
      // Inverted window: nothing is published but the frame end, which flags
      // an error since the empty window leaves all counts at zero.
      wait_for_drain;
      apply_settings(16'd5, 16'd4, 16'd25, 16'd5000, 16'd1);
      send_sample(16'd100, 16'd100, 1'b0);
      send_sample(16'd200, 16'd200, 1'b0);
      send_sample(16'd300, 16'd300, 1'b1);

      // Full window with intensity on. The receiver holds off at the start so
      // that the block fills up and has to stall the sender.
      wait_for_drain;
      apply_settings(16'd0, 16'd4095, 16'd25, 16'd5000, 16'd1);
      holds_asked <= holds_asked + 1;
      run_random_samples(320);

      // Narrow window, widest limits, and a stretch without any idling.
      wait_for_drain;
      apply_settings(16'd3, 16'd20, 16'd0, 16'hFFFF, 16'd1);
      quiet <= 1'b1;
      run_random_samples(320);
      quiet <= 1'b0;

      // Window at the top index only, crossed limits, intensity off: only
      // frame ends come out and every range is out of limits.
      wait_for_drain;
      apply_settings(16'd4095, 16'd4095, 16'hFFFF, 16'd0, 16'd0);
      run_random_samples(300);

      // Random small window and limits. Halfway the sender stops until every
      // awaited result has come back.
      wait_for_drain;
      pick_first = 16'($urandom_range(0, 30));
      apply_settings(pick_first, pick_first + 16'($urandom_range(0, 40)),
                     16'($urandom_range(0, 3000)), 16'($urandom_range(0, 6000)),
                     16'($urandom_range(1)));
      run_random_samples(160);
      wait_for_drain;
      run_random_samples(160);

      // Single-index window with equal limits, so no range is ever valid.
      wait_for_drain;
      apply_settings(16'd0, 16'd0, 16'd100, 16'd100, 16'd1);
      run_random_samples(300);

      // Fully random register words, upper bits included.
      for (int pass = 0; pass < 3; pass++) begin
         wait_for_drain;
         apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom));
         run_random_samples(110);
      end

      wait_for_drain;
      repeat (10) @(posedge clock);

      $display("Sent %0d samples in %0d frames under %0d register settings.",
               samples_sent, frames_sent, settings_applied);
      $display("Checked %0d result beats over window, limit and intensity edges and stalls.",
               results_checked);
      if (failures == 0 && outstanding == 0) begin
         $display("lidar_scan_sample_conditioner: match");
      end else begin
         $display("lidar_scan_sample_conditioner: mismatch");
      end
      $finish;
   end

endmodule
